>>> sv/imsu_pkg.sv
`default_nettype none
package imsu_pkg;

  // Lattice geometry.
  localparam int LATTICE_SIDE = 64;
  localparam int SITE_COUNT   = 4096;
  localparam int SIDE_W       = $clog2(LATTICE_SIDE);
  localparam int SIDE_SQ      = LATTICE_SIDE * LATTICE_SIDE;
  localparam int SITE_LIMIT   = (SITE_COUNT < SIDE_SQ) ? SITE_COUNT : SIDE_SQ;

  // Field widths.
  localparam int SITE_W     = 12;
  localparam int RND_W      = 32;
  localparam int E_W        = 15;
  localparam int MAG_W      = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Energy and magnetization steps.
  localparam int DE_STEP   = 4;
  localparam int DE_OFFSET = 8;
  localparam int MAG_STEP  = 2;
  localparam int ENERGY_RESET = -2 * SITE_COUNT;

  // Action codes.
  localparam logic ACT_ATTEMPT = 1'b0;
  localparam logic ACT_LOAD    = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_EIGHT = 1'b1;

  typedef logic [LATTICE_SIDE-1:0] row_t;
  typedef logic [SIDE_W-1:0]       coord_t;

  typedef struct packed {
    logic   rd_en;
    coord_t rd_row;
    logic   wr_en;
    coord_t wr_row;
    row_t   wr_data;
  } lat_req_t;

endpackage
`default_nettype wire

>>> sv/imsu_if.sv
`default_nettype none
interface imsu_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [imsu_pkg::SITE_W-1:0]  site;
  logic [imsu_pkg::RND_W-1:0]   random_fraction;
  logic                         spin_value;

  modport source (output valid, output action, output site, output random_fraction,
                  output spin_value, input ready);
  modport sink   (input valid, input action, input site, input random_fraction,
                  input spin_value, output ready);
endinterface

interface imsu_out_if;
  logic                              valid;
  logic                              ready;
  logic                              flipped;
  logic signed [imsu_pkg::E_W-1:0]   total_energy;
  logic signed [imsu_pkg::MAG_W-1:0] magnet_sum;

  modport source (output valid, output flipped, output total_energy, output magnet_sum,
                  input ready);
  modport sink   (input valid, input flipped, input total_energy, input magnet_sum,
                  output ready);
endinterface
`default_nettype wire

>>> sv/imsu_lattice.sv
`default_nettype none
module imsu_lattice (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire imsu_pkg::lat_req_t req,
  output imsu_pkg::row_t         rd_data,
  output logic                   clear_done
);

  imsu_pkg::row_t mem [imsu_pkg::LATTICE_SIDE];
  imsu_pkg::row_t rd_data_r;
  logic [imsu_pkg::SIDE_W:0] clr_cnt_r;
  logic [imsu_pkg::SIDE_W:0] clr_cnt_nxt;
  logic clearing;

  assign clearing    = (clr_cnt_r != (imsu_pkg::SIDE_W+1)'(imsu_pkg::LATTICE_SIDE));
  assign clear_done  = !clearing;
  assign clr_cnt_nxt = clr_cnt_r + (imsu_pkg::SIDE_W+1)'(1);
  assign rd_data     = rd_data_r;

  // After reset every row is swept to all spins up, one row per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt_r[imsu_pkg::SIDE_W-1:0]] <= '1;
    end else if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_row];
    end
  end

endmodule
`default_nettype wire

>>> sv/ising_metropolis_spin_update_core.sv
`default_nettype none
// Single-spin-flip Metropolis engine for a 64 x 64 periodic Ising lattice. The spins live in
// one memory of 64-bit rows; an item reads the site's row, the row above and the row below
// through its one read port and then decides and writes back, its result registered when it
// leaves the decide state, and the next item is taken only once the block is back in idle,
// so items do not overlap. A result waits in an output register; a decision stalls only while
// the previous result is still unread. After reset a clearing pass, one row per cycle, sets
// all spins up, and no input beat is taken until it ends; configuration writes are taken at
// any time.
module ising_metropolis_spin_update_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  imsu_in_if.sink                                 in_chan,
  imsu_out_if.source                              out_chan,
  input  wire logic                               cfg_we,
  input  wire logic [imsu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [imsu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_ROWC   = 5'b00100,
    ST_ROWU   = 5'b01000,
    ST_DECIDE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic                              action_r;
  logic                              spin_value_r;
  logic [imsu_pkg::RND_W-1:0]        rnd_r;
  imsu_pkg::coord_t                  x_r, y_r;
  logic                              in_range_r;
  imsu_pkg::row_t                    c_row_r;
  logic                              up_bit_r;
  logic [imsu_pkg::CFG_DATA_W-1:0]   thr4_r, thr8_r;
  logic signed [imsu_pkg::E_W-1:0]   energy_r;
  logic signed [imsu_pkg::MAG_W-1:0] magnet_r;
  logic                              out_valid_r;
  logic                              out_flipped_r;
  logic signed [imsu_pkg::E_W-1:0]   out_energy_r;
  logic signed [imsu_pkg::MAG_W-1:0] out_magnet_r;

  imsu_pkg::lat_req_t lat_req;
  imsu_pkg::row_t     rd_data;
  logic               clear_done;

  logic               accept;
  logic               commit;
  imsu_pkg::coord_t   in_x, in_y;
  logic               in_range;
  imsu_pkg::coord_t   x_left, x_right, y_up, y_down;
  logic               s_bit;
  logic [2:0]         n_up;
  logic [2:0]         n_match;
  logic               take;
  logic signed [imsu_pkg::E_W-1:0] de;
  imsu_pkg::row_t     new_row;

  imsu_lattice u_lattice (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (lat_req),
    .rd_data    (rd_data),
    .clear_done (clear_done)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && (state_r == ST_IDLE);
  assign commit        = (state_r == ST_DECIDE) && (!out_valid_r || out_chan.ready);

  assign in_x     = imsu_pkg::SIDE_W'(in_chan.site % imsu_pkg::LATTICE_SIDE);
  assign in_y     = imsu_pkg::SIDE_W'(in_chan.site / imsu_pkg::LATTICE_SIDE);
  assign in_range = (int'(in_chan.site) < imsu_pkg::SITE_LIMIT);

  // Periodic neighbours.
  assign x_left  = (x_r == '0) ? imsu_pkg::SIDE_W'(imsu_pkg::LATTICE_SIDE - 1)
                               : x_r - imsu_pkg::SIDE_W'(1);
  assign x_right = (x_r == imsu_pkg::SIDE_W'(imsu_pkg::LATTICE_SIDE - 1)) ? '0
                               : x_r + imsu_pkg::SIDE_W'(1);
  assign y_up    = (y_r == '0) ? imsu_pkg::SIDE_W'(imsu_pkg::LATTICE_SIDE - 1)
                               : y_r - imsu_pkg::SIDE_W'(1);
  assign y_down  = (y_r == imsu_pkg::SIDE_W'(imsu_pkg::LATTICE_SIDE - 1)) ? '0
                               : y_r + imsu_pkg::SIDE_W'(1);

  // In the decide state the row below sits in the memory's read register.
  assign s_bit   = c_row_r[x_r];
  assign n_up    = {2'b00, c_row_r[x_left]} + {2'b00, c_row_r[x_right]}
                 + {2'b00, up_bit_r} + {2'b00, rd_data[x_r]};
  assign n_match = s_bit ? n_up : 3'(4) - n_up;

  // The energy change of a flip is four per aligned neighbour less eight.
  assign de = imsu_pkg::E_W'(imsu_pkg::DE_STEP * int'(n_match))
            - imsu_pkg::E_W'(imsu_pkg::DE_OFFSET);

  always_comb begin
    take = 1'b0;
    if (action_r == imsu_pkg::ACT_LOAD) begin
      take = (spin_value_r != s_bit);
    end else if (n_match <= 3'd2) begin
      take = 1'b1;
    end else if (n_match == 3'd3) begin
      take = (rnd_r < thr4_r);
    end else begin
      take = (rnd_r < thr8_r);
    end
    take = take && in_range_r;
  end

  always_comb begin
    new_row       = c_row_r;
    new_row[x_r]  = ~s_bit;
  end

  always_comb begin
    lat_req = '0;
    unique case (state_r)
      ST_IDLE: begin
        lat_req.rd_en  = accept;
        lat_req.rd_row = in_y;
      end
      ST_ROWC: begin
        lat_req.rd_en  = 1'b1;
        lat_req.rd_row = y_up;
      end
      ST_ROWU: begin
        lat_req.rd_en  = 1'b1;
        lat_req.rd_row = y_down;
      end
      ST_DECIDE: begin
        lat_req.wr_en   = commit && take;
        lat_req.wr_row  = y_r;
        lat_req.wr_data = new_row;
      end
      ST_CLEAR: begin
        lat_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clear_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept)     state_nxt = ST_ROWC;
      ST_ROWC:   state_nxt = ST_ROWU;
      ST_ROWU:   state_nxt = ST_DECIDE;
      ST_DECIDE: if (commit)     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      energy_r    <= imsu_pkg::E_W'(imsu_pkg::ENERGY_RESET);
      magnet_r    <= imsu_pkg::MAG_W'(imsu_pkg::SITE_COUNT);
      thr4_r      <= '0;
      thr8_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          imsu_pkg::REG_THR_FOUR:  thr4_r <= cfg_wdata;
          imsu_pkg::REG_THR_EIGHT: thr8_r <= cfg_wdata;
        endcase
      end
      if (commit && take) begin
        energy_r <= energy_r + de;
        magnet_r <= s_bit ? magnet_r - imsu_pkg::MAG_W'(imsu_pkg::MAG_STEP)
                          : magnet_r + imsu_pkg::MAG_W'(imsu_pkg::MAG_STEP);
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r     <= in_chan.action;
      spin_value_r <= in_chan.spin_value;
      rnd_r        <= in_chan.random_fraction;
      x_r          <= in_x;
      y_r          <= in_y;
      in_range_r   <= in_range;
    end
    if (state_r == ST_ROWC) begin
      c_row_r <= rd_data;
    end
    if (state_r == ST_ROWU) begin
      up_bit_r <= rd_data[x_r];
    end
    if (commit) begin
      out_flipped_r <= take;
      out_energy_r  <= take ? energy_r + de : energy_r;
      out_magnet_r  <= !take ? magnet_r
                     : (s_bit ? magnet_r - imsu_pkg::MAG_W'(imsu_pkg::MAG_STEP)
                              : magnet_r + imsu_pkg::MAG_W'(imsu_pkg::MAG_STEP));
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.flipped      = out_flipped_r;
  assign out_chan.total_energy = out_energy_r;
  assign out_chan.magnet_sum   = out_magnet_r;

  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_ROWC) && $past(lat_req.rd_en))
    else $error("accepted beat did not start the row reads");

  a_write_only_on_decide: assert property (@(posedge clk) disable iff (!rst_n)
    lat_req.wr_en |-> (state_r == ST_DECIDE) && commit && clear_done)
    else $error("lattice written outside a committed decision");

  a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DECIDE))
    else $error("result appeared without a decision");

  a_sum_parity: assert property (@(posedge clk) disable iff (!rst_n)
    (energy_r[1:0] == 2'b00) && (magnet_r[0] == 1'(imsu_pkg::SITE_COUNT % 2)))
    else $error("energy or magnetization lost its parity");

endmodule
`default_nettype wire
